@@ rtl/core/adam_weight_update_defines.svh @@
// assertion macros shared by the checker
`ifndef ADAM_WEIGHT_UPDATE_DEFINES_SVH
`define ADAM_WEIGHT_UPDATE_DEFINES_SVH

// same-cycle implication, off during reset
`define AWU_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adam_weight_update: assertion failed");

// next-cycle implication, off during reset
`define AWU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adam_weight_update: assertion failed");

// next-cycle implication, live through reset
`define AWU_ASSERT_RESET(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("adam_weight_update: reset assertion failed");

`endif

@@ rtl/core/awu_pkg.sv @@
package awu_pkg;

   localparam int MOMENT_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(MOMENT_DEPTH);
   localparam int CLR_W        = ADDR_W + 1;
   localparam int TENSOR_COUNT = 8;
   localparam int TID_W        = $clog2(TENSOR_COUNT);
   localparam int MV_W         = 72;

   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;
   localparam int STEP_STEPS = 35;

   localparam logic [15:0] BETA1_RST = 16'd58982;
   localparam logic [15:0] BETA2_RST = 16'd65470;
   localparam logic [23:0] STEP_RST  = 24'd16777;
   localparam logic [23:0] EPS_RST   = 24'd1;

   typedef enum logic [1:0] {
      CSR_BETA1,
      CSR_BETA2,
      CSR_STEP_SIZE,
      CSR_EPSILON
   } csr_index_type;

   typedef struct packed {
      logic [15:0] beta1;
      logic [15:0] beta2;
      logic [23:0] step_size;
      logic [23:0] epsilon;
   } cfg_type;

   typedef struct packed {
      logic        load1;
      logic        load2;
      logic [15:0] beta;
   } pw_load_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       m;
      logic [39:0]       v;
      logic [32:0]       c1;
      logic [32:0]       c2;
      logic [31:0]       w;
      logic              last;
   } mom_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] w;
      logic        last;
      logic        neg;
      logic [63:0] mhat;
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] x;
   } sq_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] new_weight;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [32:0] r;
      logic [63:0] n;
   } dstep_type;

   // one restoring division step, quotient bits shift in at the bottom of n
   function automatic dstep_type div_step(input logic [32:0] r, input logic [63:0] n,
                                          input logic [32:0] c);
      logic [33:0] rt;
      logic [33:0] diff;
      dstep_type   o;
      rt   = {r, n[63]};
      diff = rt - {1'b0, c};
      if (rt >= {1'b0, c}) begin
         o.r = diff[32:0];
         o.n = {n[62:0], 1'b1};
      end else begin
         o.r = rt[32:0];
         o.n = {n[62:0], 1'b0};
      end
      return o;
   endfunction

endpackage

@@ rtl/core/awu_ram.sv @@
module awu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/awu_moment.sv @@
module awu_moment import awu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  cfg_type            cfg,
   input  pw_load_type        pw_load,
   input  logic               req_valid,
   input  logic [TID_W-1:0]   req_tensor_id,
   input  logic [ADDR_W-1:0]  req_elem_addr,
   input  logic signed [31:0] req_grad,
   input  logic signed [31:0] req_weight,
   input  logic               req_last,
   output logic               clearing,
   output mom_type            mom
);

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       g;
      logic [38:0]       gsq;
      logic [31:0]       w;
      logic              last;
      logic [32:0]       c1;
      logic [32:0]       c2;
   } p1_type;

   logic [CLR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [31:0]       pw1_ff [TENSOR_COUNT];
   logic [31:0]       pw2_ff [TENSOR_COUNT];
   logic [31:0]       pw1_sel, pw2_sel;
   logic [47:0]       pw1_prod, pw2_prod;
   logic              take;
   logic [31:0]       gmag;
   logic [63:0]       gsq_full;
   p1_type            p1_ff, p1_in;
   mom_type           mom_ff, mom_in;
   logic              p3_valid_ff;
   logic [ADDR_W-1:0] p3_addr_ff;
   logic [MV_W-1:0]   p3_mv_ff;
   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [MV_W-1:0]   ram_wdata, ram_rd, old_mv;
   logic [31:0]       m_old;
   logic [39:0]       v_old;
   logic signed [32:0] dm;
   logic signed [49:0] mprod;
   logic signed [33:0] m_raw;
   logic signed [40:0] dv;
   logic signed [57:0] vprod;
   logic signed [41:0] v_raw;
   logic [31:0]       m_new;
   logic [39:0]       v_new;

   // clearing pass over the moment store after reset
   assign clearing   = !clr_cnt_ff[CLR_W-1];
   assign clr_cnt_in = clearing ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign take     = req_valid && adv && !clearing;
   assign pw1_sel  = pw1_ff[req_tensor_id];
   assign pw2_sel  = pw2_ff[req_tensor_id];
   assign pw1_prod = pw1_sel * cfg.beta1;
   assign pw2_prod = pw2_sel * cfg.beta2;

   // beta powers per tensor
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TENSOR_COUNT; t++) begin
            pw1_ff[t] <= {BETA1_RST, 16'h0};
            pw2_ff[t] <= {BETA2_RST, 16'h0};
         end
      end else begin
         if (pw_load.load1) begin
            for (int t = 0; t < TENSOR_COUNT; t++) begin
               pw1_ff[t] <= {pw_load.beta, 16'h0};
            end
         end else if (take && req_last) begin
            pw1_ff[req_tensor_id] <= pw1_prod[47:16];
         end
         if (pw_load.load2) begin
            for (int t = 0; t < TENSOR_COUNT; t++) begin
               pw2_ff[t] <= {pw_load.beta, 16'h0};
            end
         end else if (take && req_last) begin
            pw2_ff[req_tensor_id] <= pw2_prod[47:16];
         end
      end
   end

   assign gmag     = req_grad[31] ? (~req_grad + 32'd1) : req_grad;
   assign gsq_full = gmag * gmag;

   always_comb begin
      p1_in.valid = req_valid && !clearing;
      p1_in.addr  = req_elem_addr;
      p1_in.g     = req_grad;
      p1_in.gsq   = gsq_full[62:24];
      p1_in.w     = req_weight;
      p1_in.last  = req_last;
      p1_in.c1    = 33'h1_0000_0000 - {1'b0, pw1_sel};
      p1_in.c2    = 33'h1_0000_0000 - {1'b0, pw2_sel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
      end else if (adv) begin
         p1_ff <= p1_in;
      end
   end

   assign ram_we    = clearing || (mom_ff.valid && adv);
   assign ram_waddr = clearing ? clr_cnt_ff[ADDR_W-1:0] : mom_ff.addr;
   assign ram_wdata = clearing ? '0 : {mom_ff.m, mom_ff.v};

   awu_ram #(
      .WIDTH (MV_W),
      .DEPTH (MOMENT_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (adv),
      .rd_addr (req_elem_addr),
      .rd_data (ram_rd)
   );

   // copy of the write that lands on the same edge as the read
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= mom_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_addr_ff <= mom_ff.addr;
         p3_mv_ff   <= {mom_ff.m, mom_ff.v};
      end
   end

   // forwarding of moments still in flight
   always_comb begin
      priority if (mom_ff.valid && mom_ff.addr == p1_ff.addr) begin
         old_mv = {mom_ff.m, mom_ff.v};
      end else if (p3_valid_ff && p3_addr_ff == p1_ff.addr) begin
         old_mv = p3_mv_ff;
      end else begin
         old_mv = ram_rd;
      end
   end

   assign m_old = old_mv[71:40];
   assign v_old = old_mv[39:0];

   // m = g + floor(beta1 * (m - g) / 2^16)
   assign dm    = $signed({m_old[31], m_old}) - $signed({p1_ff.g[31], p1_ff.g});
   assign mprod = dm * $signed({1'b0, cfg.beta1});
   assign m_raw = $signed({{2{p1_ff.g[31]}}, p1_ff.g}) + $signed(mprod[49:16]);

   // v = gsq + floor(beta2 * (v - gsq) / 2^16)
   assign dv    = $signed({1'b0, v_old}) - $signed({2'b00, p1_ff.gsq});
   assign vprod = dv * $signed({1'b0, cfg.beta2});
   assign v_raw = $signed({3'b000, p1_ff.gsq}) + $signed(vprod[57:16]);

   always_comb begin
      if (m_raw[33:31] == 3'b000 || m_raw[33:31] == 3'b111) begin
         m_new = m_raw[31:0];
      end else if (m_raw[33]) begin
         m_new = 32'h8000_0000;
      end else begin
         m_new = 32'h7FFF_FFFF;
      end
      if (v_raw[41]) begin
         v_new = '0;
      end else if (v_raw[40]) begin
         v_new = '1;
      end else begin
         v_new = v_raw[39:0];
      end
   end

   always_comb begin
      mom_in.valid = p1_ff.valid;
      mom_in.addr  = p1_ff.addr;
      mom_in.m     = m_new;
      mom_in.v     = v_new;
      mom_in.c1    = p1_ff.c1;
      mom_in.c2    = p1_ff.c2;
      mom_in.w     = p1_ff.w;
      mom_in.last  = p1_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mom_ff.valid <= 1'b0;
      end else if (adv) begin
         mom_ff <= mom_in;
      end
   end

   assign mom = mom_ff;

endmodule

@@ rtl/core/awu_correct.sv @@
module awu_correct import awu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  mom_type mom,
   output sq_type  sq
);

   typedef struct packed {
      logic        valid;
      logic [31:0] w;
      logic        last;
      logic        neg;
      logic [32:0] c1;
      logic [32:0] c2;
      logic        sat2;
      logic [32:0] r1;
      logic [63:0] n1;
      logic [32:0] r2;
      logic [63:0] n2;
   } dv_type;

   dv_type      dv_init;
   dv_type      dv_ff [DIV_STEPS];
   dv_type      dv_in [DIV_STEPS];
   sq_type      sq_init;
   sq_type      sq_ff [SQRT_STEPS];
   sq_type      sq_in [SQRT_STEPS];
   logic [31:0] mmag;

   // one root digit
   function automatic sq_type sqrt_step(input sq_type s);
      logic [35:0] rt;
      logic [35:0] trial;
      logic [35:0] diff;
      sq_type      o;
      o     = s;
      rt    = {s.rem, s.x[63:62]};
      trial = {2'b00, s.root, 2'b01};
      diff  = rt - trial;
      if (rt >= trial) begin
         o.rem  = diff[33:0];
         o.root = {s.root[30:0], 1'b1};
      end else begin
         o.rem  = rt[33:0];
         o.root = {s.root[30:0], 1'b0};
      end
      o.x = {s.x[61:0], 2'b00};
      return o;
   endfunction

   assign mmag = mom.m[31] ? (~mom.m + 32'd1) : mom.m;

   always_comb begin
      dv_init.valid = mom.valid;
      dv_init.w     = mom.w;
      dv_init.last  = mom.last;
      dv_init.neg   = mom.m[31];
      dv_init.c1    = mom.c1;
      dv_init.c2    = mom.c2;
      dv_init.sat2  = {1'b0, mom.v} >= {mom.c2, 8'h00};
      dv_init.r1    = '0;
      dv_init.n1    = {mmag, 32'h0};
      dv_init.r2    = dv_init.sat2 ? 33'h0 : {1'b0, mom.v[39:8]};
      dv_init.n2    = {mom.v[7:0], 56'h0};
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      dv_type    src;
      dstep_type s1, s2;
      if (k == 0) begin : g_first
         assign src = dv_init;
      end else begin : g_next
         assign src = dv_ff[k-1];
      end
      assign s1 = div_step(src.r1, src.n1, src.c1);
      assign s2 = div_step(src.r2, src.n2, src.c2);
      always_comb begin
         dv_in[k]    = src;
         dv_in[k].r1 = s1.r;
         dv_in[k].n1 = s1.n;
         dv_in[k].r2 = s2.r;
         dv_in[k].n2 = s2.n;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k].valid <= 1'b0;
         end else if (adv) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_comb begin
      sq_init.valid = dv_ff[DIV_STEPS-1].valid;
      sq_init.w     = dv_ff[DIV_STEPS-1].w;
      sq_init.last  = dv_ff[DIV_STEPS-1].last;
      sq_init.neg   = dv_ff[DIV_STEPS-1].neg;
      sq_init.mhat  = dv_ff[DIV_STEPS-1].n1;
      sq_init.rem   = '0;
      sq_init.root  = '0;
      sq_init.x     = dv_ff[DIV_STEPS-1].sat2 ? '1 : dv_ff[DIV_STEPS-1].n2;
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      sq_type src;
      if (k == 0) begin : g_first
         assign src = sq_init;
      end else begin : g_next
         assign src = sq_ff[k-1];
      end
      assign sq_in[k] = sqrt_step(src);
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k].valid <= 1'b0;
         end else if (adv) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   assign sq = sq_ff[SQRT_STEPS-1];

endmodule

@@ rtl/core/awu_step.sv @@
module awu_step import awu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  cfg_type    cfg,
   input  sq_type     sq,
   output result_type res
);

   typedef struct packed {
      logic        valid;
      logic [31:0] w;
      logic        last;
      logic        neg;
      logic        capq;
      logic [32:0] d;
      logic [55:0] plo;
      logic [55:0] phi;
   } sa_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] w;
      logic        last;
      logic        neg;
      logic        capq;
      logic [32:0] d;
      logic [87:0] prod;
   } sb_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] w;
      logic        last;
      logic        neg;
      logic        cap;
      logic [32:0] d;
      logic [32:0] r;
      logic [63:0] n;
   } sd_type;

   sa_type      sa_ff, sa_in;
   sb_type      sb_ff, sb_in;
   sd_type      sc_ff, sc_in;
   sd_type      dd_ff [STEP_STEPS];
   sd_type      dd_in [STEP_STEPS];
   logic [32:0] dsum;
   logic [34:0] step;
   logic signed [35:0] nw;
   logic [31:0] nw_sat;

   assign dsum = {1'b0, sq.root} + {9'h000, cfg.epsilon};

   // quotient of mhat alone already at the cap
   always_comb begin
      sa_in.valid = sq.valid;
      sa_in.w     = sq.w;
      sa_in.last  = sq.last;
      sa_in.neg   = sq.neg;
      sa_in.d     = (dsum == 33'h0) ? 33'h1 : dsum;
      sa_in.capq  = {3'b000, sq.mhat} >= {sa_in.d, 34'h0};
      sa_in.plo   = cfg.step_size * sq.mhat[31:0];
      sa_in.phi   = cfg.step_size * sq.mhat[63:32];
   end

   always_comb begin
      sb_in.valid = sa_ff.valid;
      sb_in.w     = sa_ff.w;
      sb_in.last  = sa_ff.last;
      sb_in.neg   = sa_ff.neg;
      sb_in.capq  = sa_ff.capq;
      sb_in.d     = sa_ff.d;
      sb_in.prod  = {sa_ff.phi, 32'h0} + {32'h0, sa_ff.plo};
   end

   // step magnitude held at 2^34
   always_comb begin
      sc_in.valid = sb_ff.valid;
      sc_in.w     = sb_ff.w;
      sc_in.last  = sb_ff.last;
      sc_in.neg   = sb_ff.neg;
      sc_in.d     = sb_ff.d;
      sc_in.cap   = sb_ff.capq || (sb_ff.prod >= {21'h0, sb_ff.d, 34'h0});
      sc_in.r     = sc_in.cap ? 33'h0 : sb_ff.prod[67:35];
      sc_in.n     = {sb_ff.prod[34:0], 29'h0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid <= 1'b0;
         sb_ff.valid <= 1'b0;
         sc_ff.valid <= 1'b0;
      end else if (adv) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
         sc_ff <= sc_in;
      end
   end

   for (genvar k = 0; k < STEP_STEPS; k++) begin : g_div
      sd_type    src;
      dstep_type s;
      if (k == 0) begin : g_first
         assign src = sc_ff;
      end else begin : g_next
         assign src = dd_ff[k-1];
      end
      assign s = div_step(src.r, src.n, src.d);
      always_comb begin
         dd_in[k]   = src;
         dd_in[k].r = s.r;
         dd_in[k].n = s.n;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dd_ff[k].valid <= 1'b0;
         end else if (adv) begin
            dd_ff[k] <= dd_in[k];
         end
      end
   end

   assign step = dd_ff[STEP_STEPS-1].cap ? 35'h4_0000_0000 : dd_ff[STEP_STEPS-1].n[34:0];

   always_comb begin
      if (dd_ff[STEP_STEPS-1].neg) begin
         nw = $signed({{4{dd_ff[STEP_STEPS-1].w[31]}}, dd_ff[STEP_STEPS-1].w})
            + $signed({1'b0, step});
      end else begin
         nw = $signed({{4{dd_ff[STEP_STEPS-1].w[31]}}, dd_ff[STEP_STEPS-1].w})
            - $signed({1'b0, step});
      end
      if (nw[35:31] == 5'b00000 || nw[35:31] == 5'b11111) begin
         nw_sat = nw[31:0];
      end else if (nw[35]) begin
         nw_sat = 32'h8000_0000;
      end else begin
         nw_sat = 32'h7FFF_FFFF;
      end
   end

   assign res.valid      = dd_ff[STEP_STEPS-1].valid;
   assign res.new_weight = nw_sat;
   assign res.last       = dd_ff[STEP_STEPS-1].last;

endmodule

@@ rtl/core/adam_weight_update.sv @@
// throughput: one request per cycle unless a held response (rsp_ready low) or the
// clearing pass stalls it; two long restoring dividers, a 32-step root
// and a 35-step divider set the pipeline depth
// reset: synchronous, active high; a clearing pass then zeroes the
// moment store, with req_ready low, while csr writes are still taken
module adam_weight_update import awu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [TID_W-1:0]   req_tensor_id,
   input  logic [ADDR_W-1:0]  req_elem_addr,
   input  logic signed [31:0] req_grad,
   input  logic signed [31:0] req_weight,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_weight,
   output logic               rsp_last_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  csr_index_type      csr_index,
   input  logic [23:0]        csr_data
);

   logic [15:0] beta1_ff, beta2_ff;
   logic [23:0] step_size_ff, epsilon_ff;
   cfg_type     cfg;
   pw_load_type pw_load;
   logic        adv;
   logic        clearing;
   mom_type     mom;
   sq_type      sq;
   result_type  res;
   logic        rsp_valid_ff;
   logic [31:0] rsp_new_weight_ff;
   logic        rsp_last_out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta1_ff     <= BETA1_RST;
         beta2_ff     <= BETA2_RST;
         step_size_ff <= STEP_RST;
         epsilon_ff   <= EPS_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BETA1:     beta1_ff     <= csr_data[15:0];
            CSR_BETA2:     beta2_ff     <= csr_data[15:0];
            CSR_STEP_SIZE: step_size_ff <= csr_data;
            CSR_EPSILON:   epsilon_ff   <= csr_data;
         endcase
      end
   end

   assign cfg.beta1     = beta1_ff;
   assign cfg.beta2     = beta2_ff;
   assign cfg.step_size = step_size_ff;
   assign cfg.epsilon   = epsilon_ff;

   // beta writes reload the power tables
   assign pw_load.load1 = csr_valid && (csr_index == CSR_BETA1);
   assign pw_load.load2 = csr_valid && (csr_index == CSR_BETA2);
   assign pw_load.beta  = csr_data[15:0];

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv && !clearing;

   awu_moment u_moment (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .cfg           (cfg),
      .pw_load       (pw_load),
      .req_valid     (req_valid),
      .req_tensor_id (req_tensor_id),
      .req_elem_addr (req_elem_addr),
      .req_grad      (req_grad),
      .req_weight    (req_weight),
      .req_last      (req_last),
      .clearing      (clearing),
      .mom           (mom)
   );

   awu_correct u_correct (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .mom   (mom),
      .sq    (sq)
   );

   awu_step u_step (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .cfg   (cfg),
      .sq    (sq),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res.valid) begin
         rsp_new_weight_ff <= res.new_weight;
         rsp_last_out_ff   <= res.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_weight = rsp_new_weight_ff;
   assign rsp_last_out   = rsp_last_out_ff;

endmodule

@@ rtl/core/awu_checker.sv @@
`include "adam_weight_update_defines.svh"

module awu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_new_weight,
   input logic        rsp_last_out
);

   // a held response keeps its payload
   `AWU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_new_weight) && $stable(rsp_last_out))

   // a stalled output stalls the request side
   `AWU_ASSERT_SAME(a_stall_blocks_req, rsp_valid && !rsp_ready, !req_ready)

   // after reset nothing is pending and the clearing pass holds off requests
   `AWU_ASSERT_RESET(a_reset_idle, reset, !rsp_valid && !req_ready)

   // no response can appear from an empty pipeline right after reset
   `AWU_ASSERT_NEXT(a_no_early_rsp, $past(reset) && !req_valid, !rsp_valid)

endmodule

bind adam_weight_update awu_checker u_awu_checker (.*);

@@ tb/sv/tb_adam_weight_update.sv @@
module tb_adam_weight_update;
   import awu_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [TID_W-1:0]   req_tensor_id;
   logic [ADDR_W-1:0]  req_elem_addr;
   logic signed [31:0] req_grad;
   logic signed [31:0] req_weight;
   logic               req_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_new_weight;
   logic               rsp_last_out;
   logic               csr_valid;
   logic               csr_ready;
   csr_index_type      csr_index;
   logic [23:0]        csr_data;

   adam_weight_update uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_tensor_id(req_tensor_id), .req_elem_addr(req_elem_addr),
      .req_grad(req_grad), .req_weight(req_weight), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_weight(rsp_new_weight), .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   localparam int LATENCY = 136;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic [31:0] new_weight;
      logic        last_out;
   } weight_result_t;

   typedef struct {
      logic [2:0]  tid;
      logic [11:0] addr;
      logic [31:0] grad;
      logic [31:0] weight;
      logic        last;
      logic        known;
      logic [31:0] want;
   } stim_row_t;

   // predictor state
   logic [15:0] p_beta1, p_beta2;
   logic [23:0] p_step, p_eps;
   logic signed [31:0] p_m [0:MOMENT_DEPTH-1];
   logic [39:0] p_v [0:MOMENT_DEPTH-1];
   logic [31:0] p_pow1 [0:TENSOR_COUNT-1];
   logic [31:0] p_pow2 [0:TENSOR_COUNT-1];

   weight_result_t weight_q[$];
   int  mismatches;
   longint cycle_count;
   bit  rsp_stall_mode;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // floor(v * 2^56 / c) saturated to 64 bits
   function automatic logic [63:0] vhat_of(logic [39:0] v, logic [32:0] c);
      logic [127:0] num, quo;
      num = {88'd0, v} << 56;
      quo = num / {95'd0, c};
      if (quo[127:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
      return quo[63:0];
   endfunction

   function automatic logic [31:0] adam_update(logic [2:0] tid, logic [11:0] addr,
                                                logic [31:0] grad, logic [31:0] weight,
                                                logic last);
      longint g, w, m, nw;
      logic signed [63:0] macc;
      logic [63:0] gmag, gsq, mmag, s, d, q, r, stp;
      logic [79:0] vacc;
      logic [39:0] v;
      logic [32:0] c1, c2;
      logic [95:0] mhat_w;
      logic [63:0] mhat;
      g = longint'($signed(grad));
      w = longint'($signed(weight));
      macc = longint'(p_beta1) * longint'(p_m[addr]) + (65536 - longint'(p_beta1)) * g;
      m = sat32(macc >>> 16);
      p_m[addr] = m[31:0];
      gmag = (g < 0) ? -g : g;
      gsq = (gmag * gmag) >> 24;
      vacc = 80'(p_beta2) * 80'(p_v[addr]) + 80'(65536 - int'(p_beta2)) * 80'(gsq);
      vacc = vacc >> 16;
      v = (vacc > 80'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : vacc[39:0];
      p_v[addr] = v;
      c1 = 33'h1_0000_0000 - {1'b0, p_pow1[tid]};
      c2 = 33'h1_0000_0000 - {1'b0, p_pow2[tid]};
      mmag = (m < 0) ? -m : m;
      mhat_w = ({32'd0, mmag} << 32) / {63'd0, c1};
      mhat = mhat_w[63:0];
      s = int_sqrt(vhat_of(v, c2));
      d = s + 64'(p_eps);
      if (d == 0) d = 1;
      q = mhat / d;
      r = mhat % d;
      if (q >= (64'd1 << 34)) begin
         stp = 64'd1 << 34;
      end else begin
         stp = 64'(p_step) * q + (64'(p_step) * r) / d;
         if (stp > (64'd1 << 34)) stp = 64'd1 << 34;
      end
      nw = (m < 0) ? w + longint'(stp) : w - longint'(stp);
      nw = sat32(nw);
      if (last) begin
         p_pow1[tid] = 32'((64'(p_pow1[tid]) * 64'(p_beta1)) >> 16);
         p_pow2[tid] = 32'((64'(p_pow2[tid]) * 64'(p_beta2)) >> 16);
      end
      return nw[31:0];
   endfunction

   function automatic void set_register(csr_index_type idx, logic [23:0] val);
      case (idx)
         CSR_BETA1: begin
            p_beta1 = val[15:0];
            foreach (p_pow1[t]) p_pow1[t] = {val[15:0], 16'd0};
         end
         CSR_BETA2: begin
            p_beta2 = val[15:0];
            foreach (p_pow2[t]) p_pow2[t] = {val[15:0], 16'd0};
         end
         CSR_STEP_SIZE: p_step = val;
         CSR_EPSILON: p_eps = val;
      endcase
   endfunction

   task automatic write_register(csr_index_type idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      set_register(idx, val);
      @(posedge clock);
   endtask

   task automatic send_request(logic [2:0] tid, logic [11:0] addr, logic [31:0] grad,
                               logic [31:0] weight, logic last, logic known,
                               logic [31:0] want);
      weight_result_t e;
      req_valid <= 1;
      req_tensor_id <= tid;
      req_elem_addr <= addr;
      req_grad <= grad;
      req_weight <= weight;
      req_last <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e.new_weight = adam_update(tid, addr, grad, weight, last);
      if (known) e.new_weight = want;
      e.last_out = last;
      weight_q.push_back(e);
   endtask

   task automatic drain(int extra);
      req_valid <= 0;
      while (weight_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // random request, mostly small address pool so moments accumulate
   task automatic send_random(int burst_gap_pct);
      logic [2:0] tid;
      logic [11:0] addr;
      logic [31:0] grad, wt;
      int pick;
      tid = $urandom_range(0, 7);
      addr = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 31));
      pick = $urandom_range(0, 9);
      if (pick < 6) grad = 32'($signed($urandom_range(0, 2 ** 26)) - 2 ** 25);
      else if (pick < 9) grad = $urandom;
      else grad = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      pick = $urandom_range(0, 9);
      if (pick < 7) wt = 32'($signed($urandom_range(0, 2 ** 28)) - 2 ** 27);
      else if (pick < 9) wt = $urandom;
      else wt = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      send_request(tid, addr, grad, wt, $urandom_range(0, 15) == 0, 0, 0);
      if ($urandom_range(0, 99) < burst_gap_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // response side
   always @(posedge clock) begin
      weight_result_t e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (weight_q.size() == 0) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10) $display("unexpected result %h", rsp_new_weight);
         end else begin
            e = weight_q.pop_front();
            if (rsp_new_weight !== e.new_weight || rsp_last_out !== e.last_out) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10)
                  $display("mismatch: expected weight %h last %b, got %h last %b",
                     e.new_weight, e.last_out, rsp_new_weight, rsp_last_out);
            end
         end
      end
      if ($urandom_range(0, 499) == 0) rsp_stall_mode <= ~rsp_stall_mode;
      rsp_ready <= rsp_stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   stim_row_t rows[$];

   initial begin
      stim_row_t row;
      int phase;
      mismatches = 0;
      cycle_count = 0;
      rsp_stall_mode = 0;
      reset <= 1;
      req_valid <= 0;
      req_tensor_id <= 0;
      req_elem_addr <= 0;
      req_grad <= 0;
      req_weight <= 0;
      req_last <= 0;
      rsp_ready <= 1;
      csr_valid <= 0;
      csr_index <= CSR_BETA1;
      csr_data <= 0;
      p_beta1 = BETA1_RST;
      p_beta2 = BETA2_RST;
      p_step = STEP_RST;
      p_eps = EPS_RST;
      foreach (p_m[i]) p_m[i] = 0;
      foreach (p_v[i]) p_v[i] = 0;
      foreach (p_pow1[t]) p_pow1[t] = {BETA1_RST, 16'd0};
      foreach (p_pow2[t]) p_pow2[t] = {BETA2_RST, 16'd0};
      repeat (2) @(posedge clock);
      reset <= 0;

      // zero gradient, fresh moments: weight passes through; then gradient and weight extremes
      rows = '{
         '{0, 0, 32'h0, 32'h0100_0000, 0, 1, 32'h0100_0000},
         '{7, 12'hFFF, 32'h0, 32'h7FFF_FFFF, 0, 1, 32'h7FFF_FFFF},
         '{3, 12'h800, 32'h0, 32'h8000_0000, 1, 1, 32'h8000_0000},
         '{1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0},
         '{1, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0},
         '{2, 2, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
         '{2, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0},
         '{4, 3, 32'hFFFF_FFFF, 32'h0, 0, 0, 0},
         '{5, 4, 32'h0000_0001, 32'h0, 1, 0, 0},
         '{6, 5, 32'h0100_0000, 32'h0100_0000, 1, 0, 0},
         '{6, 5, 32'hFF00_0000, 32'h0100_0000, 1, 0, 0},
         '{0, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0},
         '{0, 12'h555, 32'hAAAA_AAAA, 32'h5555_5555, 1, 0, 0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_request(row.tid, row.addr, row.grad, row.weight, row.last, row.known, row.want);
      end
      drain(LATENCY);

      // extremes: zero betas, zero epsilon (divisor guard), huge step size
      write_register(CSR_BETA1, 24'd0);
      write_register(CSR_BETA2, 24'd0);
      write_register(CSR_EPSILON, 24'd0);
      write_register(CSR_STEP_SIZE, 24'hFF_FFFF);
      send_request(0, 10, 32'h0, 32'h1234_5678, 0, 1, 32'h1234_5678);
      send_request(0, 11, 32'h0100_0000, 32'h0, 1, 0, 0);
      send_request(1, 12, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
      send_request(1, 12, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0);
      drain(LATENCY);

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_BETA1, 24'hFFFF);
               write_register(CSR_BETA2, 24'hFFFF);
               write_register(CSR_EPSILON, 24'hFF_FFFF);
               write_register(CSR_STEP_SIZE, 24'd1);
            end
            1: begin
               write_register(CSR_BETA1, 24'd58982);
               write_register(CSR_BETA2, 24'd65470);
               write_register(CSR_STEP_SIZE, 24'd16777);
               write_register(CSR_EPSILON, 24'd1);
            end
            default: begin
               write_register(CSR_BETA1, 24'($urandom));
               write_register(CSR_BETA2, 24'($urandom));
               write_register(CSR_STEP_SIZE, 24'($urandom));
               write_register(CSR_EPSILON, 24'($urandom_range(0, 4096)));
            end
         endcase
         repeat (230) send_random((phase % 2) ? 30 : 5);
         if (phase == 3) drain(0);
         repeat (10) send_random(0);
         drain(LATENCY);
      end

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ adam_weight_update.f @@
+incdir+rtl/core
rtl/core/awu_pkg.sv
rtl/core/awu_ram.sv
rtl/core/awu_moment.sv
rtl/core/awu_correct.sv
rtl/core/awu_step.sv
rtl/core/adam_weight_update.sv
rtl/core/awu_checker.sv
tb/sv/tb_adam_weight_update.sv
